[sv/mts_pkg.sv]
// Package for the markup token scanner: result codes, the result beat type
// and the colour name table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mts_pkg;

  localparam logic [3:0] K_BYTE     = 4'd0;
  localparam logic [3:0] K_WORD_END = 4'd1;
  localparam logic [3:0] K_SPACE    = 4'd2;
  localparam logic [3:0] K_ITALIC   = 4'd3;
  localparam logic [3:0] K_BOLD     = 4'd4;
  localparam logic [3:0] K_FG       = 4'd5;
  localparam logic [3:0] K_BG       = 4'd6;
  localparam logic [3:0] K_END      = 4'd7;
  localparam logic [3:0] K_ERROR    = 4'd8;

  localparam logic [1:0] E_BAD_NAME  = 2'd0;
  localparam logic [1:0] E_BAD_COLOR = 2'd1;
  localparam logic [1:0] E_ESC_END   = 2'd2;
  localparam logic [1:0] E_TAG_END   = 2'd3;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SP    = 8'h20;

  // Tag names, first byte in the low bits.
  localparam logic [15:0] NAME_FG = 16'h6766;
  localparam logic [15:0] NAME_BG = 16'h6762;

  localparam int NUM_COLORS = 9;

  // Result queue depth; the queue pointers are two bits wide.
  localparam int QDEPTH = 4;

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] text_byte;
    logic [3:0] attr_value;
    logic [1:0] error_code;
    logic       last_result;
  } result_t;

  // Colour names packed little-endian, up to seven bytes.
  function automatic logic [55:0] color_word(input logic [3:0] idx);
    logic [55:0] w;
    case (idx)
      4'd1:    w = 56'h00_0000_6574696877;
      4'd2:    w = 56'h00_0000_6B63616C62;
      4'd3:    w = 56'h00_0000_0000646572;
      4'd4:    w = 56'h00_0000_6E65657267;
      4'd5:    w = 56'h00_0077_6F6C6C6579;
      4'd6:    w = 56'h00_0000_0065756C62;
      4'd7:    w = 56'h61_746E_6567616D;
      4'd8:    w = 56'h00_0000_006E617963;
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [3:0] color_name_len(input logic [3:0] idx);
    logic [3:0] n;
    case (idx)
      4'd1:    n = 4'd5;
      4'd2:    n = 4'd5;
      4'd3:    n = 4'd3;
      4'd4:    n = 4'd5;
      4'd5:    n = 4'd6;
      4'd6:    n = 4'd4;
      4'd7:    n = 4'd7;
      4'd8:    n = 4'd4;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

[sv/mts_if.sv]
// Valid/ready channel interfaces for the markup token scanner.
// The field widths match result_t in mts_pkg, which is not imported here.
`timescale 1ns / 1ps
`default_nettype none

interface mts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

interface mts_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] kind;
  logic [7:0] text_byte;
  logic [3:0] attr_value;
  logic [1:0] error_code;
  logic       last_result;

  modport source (output valid, output kind, output text_byte, output attr_value,
                  output error_code, output last_result, input ready);
  modport sink   (input valid, input kind, input text_byte, input attr_value,
                  input error_code, input last_result, output ready);
endinterface

`default_nettype wire

[sv/markup_token_scanner_unit.sv]
// Markup token scanner top level: scanner state, per-byte decode and a
// four-beat result queue. Depends on mts_pkg and the interfaces in mts_if.sv.
//
//   channel | dir | payload                                           | beats
//   chars   | in  | char_in                                           | 1 per byte
//   tokens  | out | kind, text_byte, attr_value, error_code, last_res. | 0..2 per byte
//
// One byte is decoded per cycle while chars.ready is high; its results land in
// the queue at the edge that accepts it and the first can leave in the next cycle.
// A byte is taken whenever the queue has room for two beats, so with the
// output flowing the unit sustains one byte per clock while bytes yield one beat or none.
// Synchronous reset clears the scanner state and empties the queue.
// A stalled output fills the queue until it lacks room for two beats and then holds chars.ready low.
`timescale 1ns / 1ps
`default_nettype none

module markup_token_scanner_unit (
  input  wire logic clk,
  input  wire logic rst,
  mts_in_if.sink    chars,
  mts_out_if.source tokens
);
  import mts_pkg::*;

  typedef enum logic [3:0] {
    ST_BEGIN = 4'd0,
    ST_SPACE = 4'd1,
    ST_WORD  = 4'd2,
    ST_ESC   = 4'd3,
    ST_STAR  = 4'd4,
    ST_NAME  = 4'd5,
    ST_COLOR = 4'd6,
    ST_DROP  = 4'd7
  } scan_state_t;

  // Scanner state
  scan_state_t scan_state, scan_state_next;
  logic        italic_on, italic_on_next;
  logic        bold_on, bold_on_next;
  logic [15:0] tag_name_chars, tag_name_chars_next;
  logic [1:0]  tag_name_len, tag_name_len_next;
  logic [55:0] color_chars, color_chars_next;
  logic [3:0]  color_len, color_len_next;

  // Result queue
  result_t     queue [QDEPTH];
  logic [1:0]  wr_ptr, rd_ptr;
  logic [2:0]  count, count_next;

  logic        accept, pop;
  logic [7:0]  c;
  logic        is_ws;

  // Fresh scan of the byte
  logic        fr_v;
  result_t     fr_res;
  scan_state_t fr_state;
  logic        fr_clr, fr_end;

  // Tag close
  logic [55:0] cand_chars;
  logic [3:0]  cand_len;
  logic        name_fg, name_bg;
  logic        color_hit;
  logic [3:0]  color_idx;
  result_t     ct_res;
  scan_state_t ct_state;

  // Decode outcome
  logic        prim_v, use_fresh;
  result_t     prim_res;
  result_t     slot0, slot1;
  logic [1:0]  push_n;

  assign c      = chars.char_in;
  assign accept = chars.valid && chars.ready;
  assign pop    = tokens.valid && tokens.ready;
  assign is_ws  = (c == CH_SP) || (c >= 8'h09 && c <= 8'h0D);

  assign chars.ready = (count <= 3'(QDEPTH - 2));

  always_comb begin
    fr_v     = 1'b0;
    fr_res   = '0;
    fr_state = ST_BEGIN;
    fr_clr   = 1'b0;
    fr_end   = 1'b0;
    if (c == CH_NUL) begin
      fr_v        = 1'b1;
      fr_res.kind = K_END;
      fr_end      = 1'b1;
    end else if (c == CH_BSL) begin
      fr_state = ST_ESC;
    end else if (c == CH_STAR) begin
      fr_state = ST_STAR;
    end else if (c == CH_HASH) begin
      fr_state = ST_NAME;
      fr_clr   = 1'b1;
    end else if (is_ws) begin
      fr_state = ST_SPACE;
    end else begin
      fr_v             = 1'b1;
      fr_res.kind      = K_BYTE;
      fr_res.text_byte = c;
      fr_state         = ST_WORD;
    end
  end

  // A hash straight after the name closes the tag with an empty colour.
  assign cand_chars = (scan_state == ST_NAME) ? '0 : color_chars;
  assign cand_len   = (scan_state == ST_NAME) ? '0 : color_len;
  assign name_fg    = (tag_name_len == 2'd2) && (tag_name_chars == NAME_FG);
  assign name_bg    = (tag_name_len == 2'd2) && (tag_name_chars == NAME_BG);

  always_comb begin
    color_hit = 1'b0;
    color_idx = '0;
    for (int i = 0; i < NUM_COLORS; i++) begin
      if (!color_hit && cand_len == color_name_len(4'(i))
          && cand_chars == color_word(4'(i))) begin
        color_hit = 1'b1;
        color_idx = 4'(i);
      end
    end
  end

  always_comb begin
    ct_res   = '0;
    ct_state = ST_DROP;
    if (!name_fg && !name_bg) begin
      ct_res.kind       = K_ERROR;
      ct_res.error_code = E_BAD_NAME;
    end else if (!color_hit) begin
      ct_res.kind       = K_ERROR;
      ct_res.error_code = E_BAD_COLOR;
    end else begin
      ct_res.kind       = name_fg ? K_FG : K_BG;
      ct_res.attr_value = color_idx;
      ct_state          = ST_BEGIN;
    end
  end

  always_comb begin
    scan_state_next     = scan_state;
    italic_on_next      = italic_on;
    bold_on_next        = bold_on;
    tag_name_chars_next = tag_name_chars;
    tag_name_len_next   = tag_name_len;
    color_chars_next    = color_chars;
    color_len_next      = color_len;
    prim_v              = 1'b0;
    prim_res            = '0;
    use_fresh           = 1'b0;
    case (scan_state)
      ST_SPACE: begin
        if (!is_ws) begin
          prim_v        = 1'b1;
          prim_res.kind = K_SPACE;
          use_fresh     = 1'b1;
        end
      end
      ST_WORD: begin
        if (c == CH_NUL || c == CH_STAR || c == CH_HASH || is_ws) begin
          prim_v        = 1'b1;
          prim_res.kind = K_WORD_END;
          use_fresh     = 1'b1;
        end else if (c == CH_BSL) begin
          scan_state_next = ST_ESC;
        end else begin
          prim_v             = 1'b1;
          prim_res.kind      = K_BYTE;
          prim_res.text_byte = c;
        end
      end
      ST_ESC: begin
        prim_v = 1'b1;
        if (c == CH_NUL) begin
          prim_res.kind       = K_ERROR;
          prim_res.error_code = E_ESC_END;
          scan_state_next     = ST_BEGIN;
          italic_on_next      = 1'b0;
          bold_on_next        = 1'b0;
          tag_name_chars_next = '0;
          tag_name_len_next   = '0;
          color_chars_next    = '0;
          color_len_next      = '0;
        end else begin
          prim_res.kind      = K_BYTE;
          prim_res.text_byte = c;
          scan_state_next    = ST_WORD;
        end
      end
      ST_STAR: begin
        prim_v = 1'b1;
        if (c == CH_STAR) begin
          bold_on_next        = ~bold_on;
          prim_res.kind       = K_BOLD;
          prim_res.attr_value = {3'b000, ~bold_on};
          scan_state_next     = ST_BEGIN;
        end else begin
          italic_on_next      = ~italic_on;
          prim_res.kind       = K_ITALIC;
          prim_res.attr_value = {3'b000, ~italic_on};
          use_fresh           = 1'b1;
        end
      end
      ST_NAME, ST_COLOR: begin
        if (c == CH_NUL) begin
          prim_v              = 1'b1;
          prim_res.kind       = K_ERROR;
          prim_res.error_code = E_TAG_END;
          scan_state_next     = ST_BEGIN;
          italic_on_next      = 1'b0;
          bold_on_next        = 1'b0;
          tag_name_chars_next = '0;
          tag_name_len_next   = '0;
          color_chars_next    = '0;
          color_len_next      = '0;
        end else if (c == CH_HASH) begin
          prim_v          = 1'b1;
          prim_res        = ct_res;
          scan_state_next = ct_state;
          if (scan_state == ST_NAME) begin
            color_chars_next = '0;
            color_len_next   = '0;
          end
        end else if (scan_state == ST_NAME && c == CH_COLON) begin
          color_chars_next = '0;
          color_len_next   = '0;
          scan_state_next  = ST_COLOR;
        end else if (scan_state == ST_NAME) begin
          if (tag_name_len < 2'd3) begin
            if (tag_name_len == 2'd0) tag_name_chars_next[7:0] = tag_name_chars[7:0] | c;
            if (tag_name_len == 2'd1) tag_name_chars_next[15:8] = tag_name_chars[15:8] | c;
            tag_name_len_next = tag_name_len + 2'd1;
          end
        end else begin
          if (color_len < 4'd8) begin
            for (int i = 0; i < 7; i++) begin
              if (color_len == 4'(i)) begin
                color_chars_next[8*i +: 8] = color_chars[8*i +: 8] | c;
              end
            end
            color_len_next = color_len + 4'd1;
          end
        end
      end
      ST_DROP: begin
        if (c == CH_NUL) begin
          scan_state_next     = ST_BEGIN;
          italic_on_next      = 1'b0;
          bold_on_next        = 1'b0;
          tag_name_chars_next = '0;
          tag_name_len_next   = '0;
          color_chars_next    = '0;
          color_len_next      = '0;
        end
      end
      default: begin
        use_fresh = 1'b1;
      end
    endcase

    // The byte that closed a run or a star is scanned again from scratch, as is any byte in ST_BEGIN.
    if (use_fresh) begin
      scan_state_next = fr_state;
      if (fr_clr) begin
        tag_name_chars_next = '0;
        tag_name_len_next   = '0;
        color_chars_next    = '0;
        color_len_next      = '0;
      end
      if (fr_end) begin
        italic_on_next      = 1'b0;
        bold_on_next        = 1'b0;
        tag_name_chars_next = '0;
        tag_name_len_next   = '0;
        color_chars_next    = '0;
        color_len_next      = '0;
      end
    end
  end

  always_comb begin
    slot0  = '0;
    slot1  = '0;
    push_n = 2'd0;
    if (prim_v && use_fresh && fr_v) begin
      slot0             = prim_res;
      slot0.last_result = 1'b0;
      slot1             = fr_res;
      slot1.last_result = 1'b1;
      push_n            = 2'd2;
    end else if (prim_v) begin
      slot0             = prim_res;
      slot0.last_result = 1'b1;
      push_n            = 2'd1;
    end else if (use_fresh && fr_v) begin
      slot0             = fr_res;
      slot0.last_result = 1'b1;
      push_n            = 2'd1;
    end
    if (!accept) begin
      push_n = 2'd0;
    end
  end

  assign count_next = count + 3'(push_n) - 3'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_state     <= ST_BEGIN;
      italic_on      <= 1'b0;
      bold_on        <= 1'b0;
      tag_name_chars <= '0;
      tag_name_len   <= '0;
      color_chars    <= '0;
      color_len      <= '0;
      wr_ptr         <= '0;
      rd_ptr         <= '0;
      count          <= '0;
    end else begin
      if (accept) begin
        scan_state     <= scan_state_next;
        italic_on      <= italic_on_next;
        bold_on        <= bold_on_next;
        tag_name_chars <= tag_name_chars_next;
        tag_name_len   <= tag_name_len_next;
        color_chars    <= color_chars_next;
        color_len      <= color_len_next;
      end
      wr_ptr <= wr_ptr + push_n;
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      queue[wr_ptr] <= slot0;
    end
    if (push_n == 2'd2) begin
      queue[wr_ptr + 2'd1] <= slot1;
    end
  end

  assign tokens.valid       = (count != 3'd0);
  assign tokens.kind        = queue[rd_ptr].kind;
  assign tokens.text_byte   = queue[rd_ptr].text_byte;
  assign tokens.attr_value  = queue[rd_ptr].attr_value;
  assign tokens.error_code  = queue[rd_ptr].error_code;
  assign tokens.last_result = queue[rd_ptr].last_result;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 3'(QDEPTH))
    else $error("result queue overfilled");

  a_room_on_accept: assert property (@(posedge clk) disable iff (rst)
    accept |-> (count <= 3'(QDEPTH - 2)))
    else $error("byte accepted without room for two beats");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (push_n == 2'd2) |-> (!slot0.last_result && slot1.last_result))
    else $error("last_result misplaced in a two-beat result");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (count == $past(count) + 3'($past(push_n)) - 3'($past(pop))))
    else $error("queue count lost track of pushes and pops");

  a_drop_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && scan_state == ST_DROP) |-> (push_n == 2'd0))
    else $error("result produced while dropping bytes");

endmodule

`default_nettype wire
